>>> hw/rtl/dfa_eq_pkg.sv
`timescale 1ns / 1ps
package dfa_eq_pkg;
  localparam int MAX_STATES_DEF = 64;
  localparam int MAX_SYMBOLS_DEF = 16;
  localparam int OPC_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 7;
  localparam int CNT_W = 7;
  localparam int SYM_CNT_W = 5;
  localparam int LOC_W = 6;
  localparam int SYM_W = 4;

  typedef enum logic [OPC_W-1:0] {
    OP_WRITE = 2'd0,
    OP_MARK  = 2'd1,
    OP_RUN   = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STATES_FIRST  = 3'd0,
    CFG_STATES_SECOND = 3'd1,
    CFG_SYMBOL_COUNT  = 3'd2,
    CFG_START_FIRST   = 3'd3,
    CFG_START_SECOND  = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic             machine;
    logic [LOC_W-1:0] state_index;
    logic [SYM_W-1:0] symbol_index;
    logic [LOC_W-1:0] target_state;
  } load_item_t;
endpackage

>>> hw/rtl/dfa_eq_if.sv
`timescale 1ns / 1ps
interface dfa_eq_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  opcode;
  logic                        machine;
  logic [dfa_eq_pkg::LOC_W-1:0] state_index;
  logic [dfa_eq_pkg::SYM_W-1:0] symbol_index;
  logic [dfa_eq_pkg::LOC_W-1:0] target_state;
  modport source (output valid, opcode, machine, state_index, symbol_index, target_state,
                  input ready);
  modport sink (input valid, opcode, machine, state_index, symbol_index, target_state,
                output ready);
endinterface

interface dfa_eq_out_if;
  logic valid;
  logic ready;
  logic equivalent;
  modport source (output valid, equivalent, input ready);
  modport sink (input valid, equivalent, output ready);
endinterface

>>> hw/rtl/dfa_equivalence_union_find.sv
`timescale 1ns / 1ps
// load items (write, mark, unused opcode) are taken while idle and can follow back to back
// a run clears parent and rank over all slots, then joins the start states; each popped pair
// then reads, per symbol, both successors, runs two finds and joins them; a find reads one
// parent per node up to the root, then compresses the path; the final check runs one find per state
// throughput: one item at a time; no input is taken until a run's result has been transferred
// synchronous reset clears control, marks (valid bits) and registers; the tables need none
module dfa_equivalence_union_find #(
  parameter int MAX_STATES  = dfa_eq_pkg::MAX_STATES_DEF,
  parameter int MAX_SYMBOLS = dfa_eq_pkg::MAX_SYMBOLS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [dfa_eq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfa_eq_pkg::CFG_DATA_W-1:0] cfg_data,
  dfa_eq_in_if.sink   in_ch,
  dfa_eq_out_if.source out_ch
);
  localparam int SLOTS = 2 * MAX_STATES;
  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(MAX_STATES);
  localparam int YW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int TW = SW + YW;
  localparam int RW = 4;
  localparam int PW = SW + 1;

  typedef enum logic [14:0] {
    S_IDLE  = 15'd1,     S_CLR   = 15'd2,    S_POP   = 15'd4,
    S_TA    = 15'd8,     S_TB    = 15'd16,   S_FA    = 15'd32,
    S_FB    = 15'd64,    S_JOIN  = 15'd128,  S_NEXT  = 15'd256,
    S_CHK   = 15'd512,   S_CHKR  = 15'd1024, S_OUT   = 15'd2048,
    S_START = 15'd4096,  S_FWAIT = 15'd8192, S_COMP  = 15'd16384
  } state_t;

  state_t st;
  logic [dfa_eq_pkg::CNT_W-1:0] states_first, states_second;
  logic [dfa_eq_pkg::SYM_CNT_W-1:0] symbol_count;
  logic [dfa_eq_pkg::LOC_W-1:0] start_first, start_second;

  logic [SW-1:0] trans_mem [2**TW];
  logic [SW-1:0] parent_mem [SLOTS];
  logic [RW-1:0] rank_mem [SLOTS];
  logic [2*SW-1:0] stack_mem [SLOTS];
  logic [SLOTS-1:0] final_mark;

  // saturated run parameters
  logic [SW:0] n1, n2;
  logic [PW-1:0] syms;
  logic [SW-1:0] s1, s2;
  always_comb begin
    n1 = (states_first == '0) ? (SW+1)'(1) :
         ((32'(states_first) > MAX_STATES) ? (SW+1)'(MAX_STATES) : (SW+1)'(states_first));
    n2 = (states_second == '0) ? (SW+1)'(1) :
         ((32'(states_second) > MAX_STATES) ? (SW+1)'(MAX_STATES) : (SW+1)'(states_second));
    syms = (symbol_count == '0) ? PW'(1) :
           ((32'(symbol_count) > MAX_SYMBOLS) ? PW'(MAX_SYMBOLS) : PW'(symbol_count));
    s1 = ((SW+1)'(start_first) < n1) ? SW'(start_first) : SW'(n1 - 1'b1);
    s2 = SW'(n1 + (((SW+1)'(start_second) < n2) ? (SW+1)'(start_second) : (n2 - 1'b1)));
  end

  logic [SW-1:0] cnt, pa, pb, ta, tb, ra, rb, fx, fr, root;
  logic [PW-1:0] sym;
  logic [SW:0] sp;
  logic fb_phase, eq, compress;
  logic [SW-1:0] par_q;
  logic [RW-1:0] rank_a, rank_b;
  logic [SW-1:0] trans_q;
  logic [2*SW-1:0] stack_q;

  // combined state to table address and successor mapping
  function automatic logic [TW-1:0] taddr(input logic [SW-1:0] c, input logic [SW:0] k1,
                                         input logic [PW-1:0] s);
    logic m;
    logic [SW-1:0] loc;
    m = ((SW+1)'(c) >= k1);
    loc = m ? SW'((SW+1)'(c) - k1) : c;
    taddr = {m, loc[LW-1:0], s[YW-1:0]};
  endfunction

  function automatic logic [SW-1:0] tmap(input logic [SW-1:0] c, input logic [SW-1:0] t,
                                        input logic [SW:0] k1, input logic [SW:0] k2);
    logic m;
    logic [SW:0] k, tt;
    m = ((SW+1)'(c) >= k1);
    k = m ? k2 : k1;
    tt = ((SW+1)'(t) >= k) ? (k - 1'b1) : (SW+1)'(t);
    tmap = m ? SW'(k1 + tt) : SW'(tt);
  endfunction

  function automatic logic fin(input logic [SLOTS-1:0] f, input logic [SW-1:0] c,
                               input logic [SW:0] k1);
    logic [SW-1:0] i;
    i = ((SW+1)'(c) < k1) ? c : SW'(MAX_STATES) + SW'((SW+1)'(c) - k1);
    fin = f[i];
  endfunction

  logic in_fire, load_ok;
  assign in_ch.ready = (st == S_IDLE) && !out_ch.valid;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign load_ok = (32'(in_ch.state_index) < MAX_STATES) &&
                   (32'(in_ch.symbol_index) < MAX_SYMBOLS);

  logic [TW-1:0] rd_taddr;
  logic [SW-1:0] rd_paddr;
  logic par_we, rank_we, push_we;
  logic [SW-1:0] par_wa, par_wd, rank_wa;
  logic [RW-1:0] rank_wd;
  logic [2*SW-1:0] push_wd;
  logic [SW-1:0] push_wa;

  // memories: single write, single registered read each
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.opcode == dfa_eq_pkg::OP_WRITE && load_ok)
      trans_mem[{in_ch.machine, LW'(in_ch.state_index), YW'(in_ch.symbol_index)}] <=
        SW'(in_ch.target_state);
    trans_q <= trans_mem[rd_taddr];
    if (par_we) parent_mem[par_wa] <= par_wd;
    par_q <= parent_mem[rd_paddr];
    if (rank_we) rank_mem[rank_wa] <= rank_wd;
    if (push_we) stack_mem[push_wa] <= push_wd;
    stack_q <= stack_mem[SW'(sp - 1'b1)];
  end

  always_comb begin
    rd_taddr = taddr(fb_phase ? pb : pa, n1, sym);
    rd_paddr = fx;
    par_we = 1'b0; par_wa = cnt; par_wd = cnt;
    rank_we = 1'b0; rank_wa = cnt; rank_wd = '0;
    push_we = 1'b0; push_wa = SW'(sp); push_wd = {ta, tb};
    if (st == S_CLR) begin
      par_we = 1'b1; rank_we = 1'b1;
    end else if (st == S_JOIN && ra != rb) begin
      if (rank_a > rank_b) begin
        par_we = 1'b1; par_wa = rb; par_wd = ra;
      end else begin
        par_we = 1'b1; par_wa = ra; par_wd = rb;
        if (rank_a == rank_b) begin
          rank_we = 1'b1; rank_wa = rb; rank_wd = rank_b + 1'b1;
        end
      end
      push_we = (32'(sp) < SLOTS);
    end else if (st == S_COMP && par_q != root) begin
      // path compression on the way back
      par_we = 1'b1; par_wa = fx; par_wd = root;
    end
  end

  logic [RW-1:0] rank_rd;
  always_ff @(posedge clk) rank_rd <= rank_mem[fx];

  // find walks fx up to root, then compresses from fr; caller = find_for (ta, tb or check)
  logic [1:0] find_for;
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      states_first <= 7'd1; states_second <= 7'd1; symbol_count <= 5'd1;
      start_first <= '0; start_second <= '0;
      final_mark <= '0;
      out_ch.valid <= 1'b0;
      out_ch.equivalent <= 1'b0;
      cnt <= '0; sp <= '0; sym <= '0; fb_phase <= 1'b0; eq <= 1'b1; find_for <= '0;
      compress <= 1'b0;
      pa <= '0; pb <= '0; ta <= '0; tb <= '0; ra <= '0; rb <= '0;
      fx <= '0; fr <= '0; root <= '0; rank_a <= '0; rank_b <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          dfa_eq_pkg::CFG_STATES_FIRST:  states_first <= cfg_data;
          dfa_eq_pkg::CFG_STATES_SECOND: states_second <= cfg_data;
          dfa_eq_pkg::CFG_SYMBOL_COUNT:  symbol_count <= cfg_data[4:0];
          dfa_eq_pkg::CFG_START_FIRST:   start_first <= cfg_data[5:0];
          dfa_eq_pkg::CFG_START_SECOND:  start_second <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (in_fire) begin
            case (in_ch.opcode)
              dfa_eq_pkg::OP_MARK:
                if (32'(in_ch.state_index) < MAX_STATES)
                  final_mark[{in_ch.machine, LW'(in_ch.state_index)}] <= 1'b1;
              dfa_eq_pkg::OP_RUN: begin
                st <= S_CLR; cnt <= '0;
              end
              default: ;
            endcase
          end
        end
        S_CLR: begin
          cnt <= cnt + 1'b1;
          if (32'(cnt) == SLOTS - 1) st <= S_START;
        end
        S_START: begin
          // start states are fresh roots of rank zero: s1 under s2
          ta <= s1; tb <= s2; ra <= s1; rb <= s2;
          rank_a <= '0; rank_b <= '0; sp <= '0;
          // last symbol, so the join falls straight through to the first pop
          sym <= syms - 1'b1;
          st <= S_JOIN;
        end
        S_POP: begin
          if (sp == '0) begin
            cnt <= '0; eq <= 1'b1; st <= S_CHK;
          end else begin
            pa <= stack_q[2*SW-1:SW]; pb <= stack_q[SW-1:0];
            sp <= sp - 1'b1; sym <= '0; fb_phase <= 1'b0;
            st <= S_TA;
          end
        end
        S_TA: begin
          fb_phase <= 1'b1; st <= S_TB;
        end
        S_TB: begin
          ta <= tmap(pa, trans_q, n1, n2);
          st <= S_FA;
        end
        S_FA: begin
          tb <= tmap(pb, trans_q, n1, n2);
          fx <= ta; fr <= ta; find_for <= 2'd0;
          st <= S_FWAIT;
        end
        S_FWAIT: st <= compress ? S_COMP : S_FB;
        S_FB: begin
          // par_q, rank_rd belong to fx
          if (par_q == fx) begin
            root <= fx; fx <= fr; compress <= 1'b1;
            if (find_for == 2'd0) begin ra <= fx; rank_a <= rank_rd; end
            else if (find_for == 2'd1) begin rb <= fx; rank_b <= rank_rd; end
            st <= S_FWAIT;
          end else begin
            fx <= par_q; st <= S_FWAIT;
          end
        end
        S_COMP: begin
          // par_q belongs to fx
          if (par_q == root) begin
            compress <= 1'b0;
            if (find_for == 2'd0) begin
              fx <= tb; fr <= tb; find_for <= 2'd1; st <= S_FWAIT;
            end else if (find_for == 2'd1) st <= S_JOIN;
            else st <= S_CHKR;
          end else begin
            fx <= par_q; st <= S_FWAIT;
          end
        end
        S_JOIN: begin
          if (ra != rb && 32'(sp) < SLOTS) sp <= sp + 1'b1;
          st <= S_NEXT;
        end
        S_NEXT: begin
          if (sym + 1'b1 >= syms) st <= S_POP;
          else begin
            sym <= sym + 1'b1; fb_phase <= 1'b0; st <= S_TA;
          end
        end
        S_CHK: begin
          if ((SW+1)'(cnt) + (SW+1)'(1) > n1 + n2 + (SW+1)'(1)) st <= S_OUT;
          else begin
            fx <= cnt; fr <= cnt; find_for <= 2'd2; st <= S_FWAIT;
          end
        end
        S_CHKR: begin
          if (fin(final_mark, cnt, n1) != fin(final_mark, root, n1)) eq <= 1'b0;
          if ((SW+1)'(cnt) + 1'b1 >= n1 + n2) st <= S_OUT;
          else begin cnt <= cnt + 1'b1; st <= S_CHK; end
        end
        S_OUT: begin
          out_ch.valid <= 1'b1; out_ch.equivalent <= eq; st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  a_idle: assert property (@(posedge clk) disable iff (rst) out_ch.valid |-> st == S_IDLE)
    else $error("result shown while a run is active");
  a_stack: assert property (@(posedge clk) disable iff (rst) 32'(sp) <= SLOTS)
    else $error("pair stack overflow");
  a_ready: assert property (@(posedge clk) disable iff (rst) in_ch.ready |-> st == S_IDLE)
    else $error("ready outside idle");
  a_run: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_ch.opcode == dfa_eq_pkg::OP_RUN) |=> st == S_CLR)
    else $error("run did not start clearing");
  a_out: assert property (@(posedge clk) disable iff (rst) st == S_OUT |=> out_ch.valid)
    else $error("result lost");
endmodule

>>> sim/tb_dfa_equivalence_union_find.sv
`timescale 1ns / 1ps
module tb_dfa_equivalence_union_find;
  localparam int NSTATES = dfa_eq_pkg::MAX_STATES_DEF;
  localparam int NSYMS   = dfa_eq_pkg::MAX_SYMBOLS_DEF;
  localparam int SLOTS   = 2 * NSTATES;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [dfa_eq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dfa_eq_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  dfa_eq_in_if  in_ch ();
  dfa_eq_out_if out_ch ();

  dfa_equivalence_union_find DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [6:0] reg_states [2];
  logic [4:0] reg_syms;
  logic [5:0] reg_start [2];
  logic [dfa_eq_pkg::LOC_W-1:0] succ_tab [SLOTS*NSYMS];
  bit   final_mark [SLOTS];
  int   parent [SLOTS];
  int   rank_of [SLOTS];

  // generator bookkeeping (order of generation equals order of transfer)
  bit gen_written [2][NSTATES][NSYMS];
  bit gen_marked [2][NSTATES];

  dfa_eq_pkg::load_item_t pending_items[$];
  bit         equiv_expected[$];
  int         fail_count = 0;
  int         items_made = 0;
  bit         hold_off = 1'b0;

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    fail_count++;
  endtask

  function automatic int sat(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int find_class(input int x);
    int r;
    int nx;
    r = x;
    while (parent[r] != r) r = parent[r];
    while (parent[x] != r) begin
      nx = parent[x];
      parent[x] = r;
      x = nx;
    end
    return r;
  endfunction

  function automatic void merge_classes(input int a, input int b);
    if (rank_of[a] > rank_of[b]) begin
      parent[b] = a;
    end else begin
      parent[a] = b;
      if (rank_of[a] == rank_of[b]) rank_of[b]++;
    end
  endfunction

  function automatic int next_state(input int c, input int sym, input int n1, input int n2);
    int m;
    int loc;
    int cnt;
    int t;
    m = (c < n1) ? 0 : 1;
    loc = m ? c - n1 : c;
    cnt = m ? n2 : n1;
    t = int'(succ_tab[((m * NSTATES) + loc) * NSYMS + sym]);
    if (t >= cnt) t = cnt - 1;
    return m ? n1 + t : t;
  endfunction

  function automatic bit is_accepting(input int c, input int n1);
    return (c < n1) ? final_mark[c] : final_mark[NSTATES + c - n1];
  endfunction

  function automatic bit languages_match();
    int n1, n2, syms, s1, s2, sp, a, b, ta, tb, ra, rb;
    int stk_a [SLOTS];
    int stk_b [SLOTS];
    n1 = sat(int'(reg_states[0]), NSTATES);
    n2 = sat(int'(reg_states[1]), NSTATES);
    syms = sat(int'(reg_syms), NSYMS);
    s1 = (int'(reg_start[0]) < n1) ? int'(reg_start[0]) : n1 - 1;
    s2 = n1 + ((int'(reg_start[1]) < n2) ? int'(reg_start[1]) : n2 - 1);
    for (int i = 0; i < SLOTS; i++) begin
      parent[i] = i;
      rank_of[i] = 0;
    end
    merge_classes(find_class(s1), find_class(s2));
    stk_a[0] = s1;
    stk_b[0] = s2;
    sp = 1;
    while (sp > 0) begin
      sp--;
      a = stk_a[sp];
      b = stk_b[sp];
      for (int sym = 0; sym < syms; sym++) begin
        ta = next_state(a, sym, n1, n2);
        tb = next_state(b, sym, n1, n2);
        ra = find_class(ta);
        rb = find_class(tb);
        if (ra != rb) begin
          merge_classes(ra, rb);
          if (sp < SLOTS) begin
            stk_a[sp] = ta;
            stk_b[sp] = tb;
            sp++;
          end
        end
      end
    end
    for (int i = 0; i < n1 + n2; i++)
      if (is_accepting(i, n1) != is_accepting(find_class(i), n1)) return 1'b0;
    return 1'b1;
  endfunction

  // driver
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.opcode <= '0;
      in_ch.machine <= 1'b0;
      in_ch.state_index <= '0;
      in_ch.symbol_index <= '0;
      in_ch.target_state <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0 && !hold_off) begin
        dfa_eq_pkg::load_item_t it;
        int r;
        it = pending_items.pop_front();
        in_ch.opcode <= it.opcode;
        in_ch.machine <= it.machine;
        in_ch.state_index <= it.state_index;
        in_ch.symbol_index <= it.symbol_index;
        in_ch.target_state <= it.target_state;
        in_ch.valid <= 1'b1;
        r = $urandom_range(0, 99);
        gap_left <= (r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // input monitor feeds the predictor on every transfer
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      case (dfa_eq_pkg::opcode_t'(in_ch.opcode))
        dfa_eq_pkg::OP_WRITE: succ_tab[((in_ch.machine * NSTATES) + in_ch.state_index) * NSYMS
                                       + in_ch.symbol_index] = in_ch.target_state;
        dfa_eq_pkg::OP_MARK:  final_mark[in_ch.machine * NSTATES + in_ch.state_index] = 1'b1;
        dfa_eq_pkg::OP_RUN:   equiv_expected.insert(equiv_expected.size(), languages_match());
        default: ;
      endcase
    end
  end

  // result side: random back-pressure and checking
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (equiv_expected.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          bit want;
          want = equiv_expected.pop_front();
          if (out_ch.equivalent !== want)
            report_mismatch($sformatf("equivalent got %0b want %0b", out_ch.equivalent, want));
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        int r;
        r = $urandom_range(0, 99);
        out_ch.ready <= 1'b1;
        stall_left <= (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 50);
      end
    end
  end

  task automatic push_item(input dfa_eq_pkg::opcode_t op, input bit m, input int st,
                           input int sym, input int tgt);
    dfa_eq_pkg::load_item_t it;
    it.opcode = op;
    it.machine = m;
    it.state_index = dfa_eq_pkg::LOC_W'(st);
    it.symbol_index = dfa_eq_pkg::SYM_W'(sym);
    it.target_state = dfa_eq_pkg::LOC_W'(tgt);
    if (op == dfa_eq_pkg::OP_WRITE) gen_written[m][st][sym] = 1'b1;
    if (op == dfa_eq_pkg::OP_MARK) gen_marked[m][st] = 1'b1;
    pending_items.insert(pending_items.size(), it);
    items_made++;
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_ch.valid || equiv_expected.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input dfa_eq_pkg::cfg_index_t idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= dfa_eq_pkg::CFG_DATA_W'(val);
    case (idx)
      dfa_eq_pkg::CFG_STATES_FIRST:  reg_states[0] = 7'(val);
      dfa_eq_pkg::CFG_STATES_SECOND: reg_states[1] = 7'(val);
      dfa_eq_pkg::CFG_SYMBOL_COUNT:  reg_syms = 5'(val);
      dfa_eq_pkg::CFG_START_FIRST:   reg_start[0] = 6'(val);
      dfa_eq_pkg::CFG_START_SECOND:  reg_start[1] = 6'(val);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input int n1, input int n2, input int sc, input int a, input int b);
    wait_drained();
    write_reg(dfa_eq_pkg::CFG_STATES_FIRST, n1);
    write_reg(dfa_eq_pkg::CFG_STATES_SECOND, n2);
    write_reg(dfa_eq_pkg::CFG_SYMBOL_COUNT, sc);
    write_reg(dfa_eq_pkg::CFG_START_FIRST, a);
    write_reg(dfa_eq_pkg::CFG_START_SECOND, b);
  endtask

  // fill every table entry a run will read that has not been written yet
  task automatic complete_tables();
    int n [2];
    int syms;
    n[0] = sat(int'(reg_states[0]), NSTATES);
    n[1] = sat(int'(reg_states[1]), NSTATES);
    syms = sat(int'(reg_syms), NSYMS);
    for (int m = 0; m < 2; m++)
      for (int s = 0; s < n[m]; s++)
        for (int y = 0; y < syms; y++)
          if (!gen_written[m][s][y])
            push_item(dfa_eq_pkg::OP_WRITE, 1'(m), s, y, $urandom_range(0, 63));
  endtask

  // machine 1 made a copy of machine 0, so the run should come out equal
  task automatic mirror_machines();
    int n;
    int syms;
    int t;
    n = sat(int'(reg_states[0]), NSTATES);
    syms = sat(int'(reg_syms), NSYMS);
    for (int s = 0; s < n; s++) begin
      for (int y = 0; y < syms; y++) begin
        t = $urandom_range(0, n - 1);
        push_item(dfa_eq_pkg::OP_WRITE, 1'b0, s, y, t);
        push_item(dfa_eq_pkg::OP_WRITE, 1'b1, s, y, t);
      end
      if (gen_marked[0][s] && !gen_marked[1][s]) push_item(dfa_eq_pkg::OP_MARK, 1'b1, s, 0, 0);
      if (gen_marked[1][s] && !gen_marked[0][s]) push_item(dfa_eq_pkg::OP_MARK, 1'b0, s, 0, 0);
    end
  endtask

  task automatic random_run(input bit mirrored);
    int n [2];
    int k;
    int m;
    int r;
    n[0] = sat(int'(reg_states[0]), NSTATES);
    n[1] = sat(int'(reg_states[1]), NSTATES);
    k = $urandom_range(0, 12);
    for (int i = 0; i < k; i++) begin
      m = $urandom_range(0, 1);
      r = $urandom_range(0, 99);
      if (r < 70)
        push_item(dfa_eq_pkg::OP_WRITE, 1'(m), ($urandom_range(0, 3) == 0) ?
                  $urandom_range(0, 63) : $urandom_range(0, n[m] - 1),
                  $urandom_range(0, 15), $urandom_range(0, 63));
      else if (r < 85)
        push_item(dfa_eq_pkg::OP_MARK, 1'(m), $urandom_range(0, n[m] - 1),
                  $urandom_range(0, 15), $urandom_range(0, 63));
      else
        push_item(dfa_eq_pkg::OP_NONE, 1'(m), $urandom_range(0, 63), $urandom_range(0, 15),
                  $urandom_range(0, 63));
    end
    if (mirrored) mirror_machines();
    complete_tables();
    push_item(dfa_eq_pkg::OP_RUN, 1'($urandom_range(0, 1)), $urandom_range(0, 63),
              $urandom_range(0, 15), $urandom_range(0, 63));
  endtask

  initial begin
    int n1, n2, sc;
    bit mir;
    bit paused_once;
    paused_once = 1'b0;
    reg_states[0] = 1;
    reg_states[1] = 1;
    reg_syms = 1;
    reg_start[0] = 0;
    reg_start[1] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset config, marks on either side, unused opcode, field extremes
    push_item(dfa_eq_pkg::OP_WRITE, 1'b0, 0, 0, 0);
    push_item(dfa_eq_pkg::OP_WRITE, 1'b1, 0, 0, 63);
    push_item(dfa_eq_pkg::OP_RUN, 1'b0, 0, 0, 0);
    push_item(dfa_eq_pkg::OP_MARK, 1'b0, 0, 0, 0);
    push_item(dfa_eq_pkg::OP_RUN, 1'b1, 63, 15, 63);
    push_item(dfa_eq_pkg::OP_NONE, 1'b1, 63, 15, 63);
    push_item(dfa_eq_pkg::OP_MARK, 1'b1, 0, 15, 63);
    push_item(dfa_eq_pkg::OP_RUN, 1'b0, 0, 0, 0);
    push_item(dfa_eq_pkg::OP_WRITE, 1'b1, 63, 15, 63);
    push_item(dfa_eq_pkg::OP_MARK, 1'b1, 63, 0, 0);
    push_item(dfa_eq_pkg::OP_WRITE, 1'b0, 63, 15, 0);

    // extreme and out-of-range register settings
    set_config(64, 64, 1, 63, 63);
    random_run(1'b0);
    set_config(1, 1, 16, 0, 0);
    random_run(1'b0);
    random_run(1'b1);
    set_config(127, 0, 1, 5, 63);
    random_run(1'b0);
    set_config(2, 3, 31, 63, 0);
    random_run(1'b0);
    set_config(0, 127, 0, 0, 40);
    random_run(1'b0);
    set_config(4, 4, 16, 3, 3);
    random_run(1'b1);

    while (items_made < 1400) begin
      n1 = $urandom_range(1, 10);
      n2 = $urandom_range(1, 10);
      sc = $urandom_range(1, 4);
      mir = ($urandom_range(0, 2) == 0);
      if (mir) n2 = n1;
      set_config(n1, n2, sc, $urandom_range(0, n1 - 1),
                 mir ? int'(reg_start[0]) : $urandom_range(0, n2 - 1));
      if (mir) write_reg(dfa_eq_pkg::CFG_START_SECOND, int'(reg_start[0]));
      for (int r = 0; r < 6; r++) random_run(mir);
      if (!paused_once && items_made > 700) begin
        // sender holds off until every outstanding result is back
        paused_once = 1'b1;
        @(posedge clk);
        hold_off <= 1'b1;
        while (in_ch.valid || equiv_expected.size() > 0)
          @(posedge clk);
        @(posedge clk);
        hold_off <= 1'b0;
      end
    end

    wait_drained();
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
